/* rtl/core/pcfi_pkg.sv */
package pcfi_pkg;

   localparam int FIFO_DEPTH = 4096;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
   localparam int MAX_BLOCK  = 64;
   localparam int CNT_W      = 7;
   localparam int SAMPLE_W   = 16;
   localparam int NCH_W      = 4;
   localparam int RATE_W     = 18;
   localparam int MS_W       = 10;
   localparam int PROD_W     = RATE_W + MS_W;
   localparam int DEN_W      = 10;
   localparam int DIV_CNT_W  = $clog2(PROD_W + 1);
   localparam int MS_PER_S   = 1000;
   localparam int GAIN_W     = CNT_W + 1;
   localparam int SCALED_W   = SAMPLE_W + GAIN_W + 1;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   // ceil(2^38 / 1000): floor(x * FADE_RECIP / 2^38) equals x / 1000 for any 28-bit x
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 38;
   localparam int FADE_W      = PROD_W + RECIP_W;
   localparam int FQ_W        = FADE_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] FADE_RECIP = 29'd274877907;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = RATE_W;
   localparam logic [CSR_ADDR_W-1:0] CFG_NUM_CHANNELS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CFG_SAMPLE_RATE  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CFG_FADE_MS      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CFG_FADE_ENABLE  = 2'd3;

   localparam logic MODE_PUSH = 1'b0;

   localparam int DIV_SEL_W = 2;
   localparam logic [DIV_SEL_W-1:0] DIV_FRAMES = 2'd0;
   localparam logic [DIV_SEL_W-1:0] DIV_SCALE  = 2'd2;

   typedef struct packed {
      logic                 load;
      logic                 setup;
      logic                 div_start;
      logic [DIV_SEL_W-1:0] div_sel;
      logic                 take_frames;
      logic                 take_n;
      logic                 rd;
      logic                 take_data;
      logic                 mul;
      logic                 take_scale;
      logic                 emit;
   } dp_cmd_type;

   typedef struct packed {
      logic in_push;
      logic in_zero;
      logic fade;
      logic div_done;
      logic copy_now;
      logic fade_now;
      logic last_item;
      logic out_free;
   } dp_status_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

/* rtl/core/pcfi_ram.sv */
module pcfi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/pcfi_datapath.sv */
module pcfi_datapath
   import pcfi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         st,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,
   output logic                  rsp_tlast,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [NCH_W-1:0]  nch_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [MS_W-1:0]   ms_ff;
   logic              en_ff;

   logic [PTR_W-1:0]  rp_ff, wp_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              pend_ff;

   logic [CNT_W-1:0]  req_ff, copied_ff, k_ff, frames_ff, n_ff, frame_ff;
   logic [NCH_W-1:0]  ch_ff;
   logic              fade_ff, under_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [FQ_W-1:0]   fq_ff;

   logic [PROD_W-1:0]    dnum_ff;
   logic [DEN_W-1:0]     drem_ff, dden_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic                 dbusy_ff, ddone_ff;

   logic [SAMPLE_W-1:0]        samp_ff;
   logic signed [SCALED_W-1:0] mul_ff;

   logic                rsp_valid_ff, rsp_last_ff, rsp_pad_ff, rsp_under_ff;
   logic [SAMPLE_W-1:0] rsp_data_ff;

   logic [SAMPLE_W-1:0] in_sample;
   logic [CNT_W-1:0]    in_count, req_sat, copied_in;
   logic                push_ok;
   logic [SAMPLE_W-1:0] ram_q;
   logic [NCH_W-1:0]    nch_eff;

   logic [DEN_W:0]       trial, diff;
   logic                 ge;
   logic [PROD_W-1:0]    div_num_in;
   logic [DEN_W-1:0]     div_den_in;
   logic [SCALED_W-1:0]  mag;
   logic [FADE_W-1:0]    fade_prod;

   logic [GAIN_W-1:0]             gain;
   logic signed [SCALED_W-2:0]    prod_s;
   logic signed [SCALED_W-1:0]    scaled;
   logic [SCALED_W-1:0]           qq, qres;
   logic [CNT_W-1:0]              n_in;
   logic                          padded;

   assign in_sample = req_tdata[SAMPLE_W-1:0];
   assign in_count  = req_tdata[SAMPLE_W+CNT_W-1:SAMPLE_W];
   assign req_sat   = (in_count > CNT_W'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK) : in_count;
   assign copied_in = (fill_ff < FILL_W'(req_sat)) ? fill_ff[CNT_W-1:0] : req_sat;
   assign push_ok   = cmd.load && (req_tuser == MODE_PUSH)
                      && (fill_ff < FILL_W'(FIFO_DEPTH));
   assign nch_eff   = (nch_ff == '0) ? NCH_W'(1) : nch_ff;

   pcfi_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wp_ff),
      .wr_data (in_sample),
      .rd_en   (cmd.rd),
      .rd_addr (rp_ff),
      .rd_data (ram_q)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nch_ff  <= NCH_W'(2);
         rate_ff <= RATE_W'(48000);
         ms_ff   <= MS_W'(10);
         en_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CFG_NUM_CHANNELS: nch_ff  <= csr_wdata[NCH_W-1:0];
            CFG_SAMPLE_RATE:  rate_ff <= csr_wdata[RATE_W-1:0];
            CFG_FADE_MS:      ms_ff   <= csr_wdata[MS_W-1:0];
            CFG_FADE_ENABLE:  en_ff   <= csr_wdata[0];
         endcase
      end
   end

   // queue pointers and fade arming
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff   <= '0;
         wp_ff   <= '0;
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (push_ok) begin
            wp_ff   <= ptr_inc(wp_ff);
            fill_ff <= fill_ff + 1'b1;
         end else if (cmd.rd) begin
            rp_ff   <= ptr_inc(rp_ff);
            fill_ff <= fill_ff - 1'b1;
         end
         if (cmd.setup) begin
            if (fade_ff) begin
               pend_ff <= 1'b0;
            end else if (en_ff && under_ff) begin
               pend_ff <= 1'b1;
            end
         end
      end
   end

   // shared restoring divider, one quotient bit per cycle
   assign trial = {drem_ff, dnum_ff[PROD_W-1]};
   assign ge    = trial >= {1'b0, dden_ff};
   assign diff  = trial - {1'b0, dden_ff};
   assign mag   = mul_ff[SCALED_W-1] ? SCALED_W'(-mul_ff) : SCALED_W'(mul_ff);

   always_comb begin
      unique case (cmd.div_sel)
         DIV_FRAMES: begin
            div_num_in = PROD_W'(copied_ff);
            div_den_in = DEN_W'(nch_eff);
         end
         default: begin
            div_num_in = PROD_W'(mag);
            div_den_in = {n_ff, 1'b0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= dbusy_ff && (dcnt_ff == DIV_CNT_W'(1));
         if (cmd.div_start) begin
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff && (dcnt_ff == DIV_CNT_W'(1))) begin
            dbusy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dnum_ff <= div_num_in;
         dden_ff <= div_den_in;
         drem_ff <= '0;
         dcnt_ff <= DIV_CNT_W'(PROD_W);
      end else if (dbusy_ff) begin
         drem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         dnum_ff <= {dnum_ff[PROD_W-2:0], ge};
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   // fade frames per millisecond product over 1000, by reciprocal multiplication
   assign fade_prod = FADE_W'(prod_ff) * FADE_W'(FADE_RECIP);

   // fade length: at least one frame when the block holds a whole frame, at most the whole frames produced
   always_comb begin
      if (fq_ff == '0) begin
         n_in = (frames_ff == '0) ? '0 : CNT_W'(1);
      end else if (fq_ff >= FQ_W'(frames_ff)) begin
         n_in = frames_ff;
      end else begin
         n_in = fq_ff[CNT_W-1:0];
      end
   end

   assign gain   = {1'b0, frame_ff} + 1'b1;
   assign prod_s = $signed((SCALED_W-1)'($signed(samp_ff)))
                   * $signed((SCALED_W-1)'(gain));
   assign scaled = $signed({prod_s, 1'b0}) + $signed(SCALED_W'(n_ff));
   // floor of a negative ratio rounds the magnitude up
   assign qq     = dnum_ff[SCALED_W-1:0]
                   + SCALED_W'(mul_ff[SCALED_W-1] && (drem_ff != '0));
   assign qres   = mul_ff[SCALED_W-1] ? SCALED_W'(-qq) : qq;
   assign padded = k_ff >= copied_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_sat;
         copied_ff <= copied_in;
         under_ff  <= copied_in == '0;
         fade_ff   <= en_ff && pend_ff && (copied_in != '0);
         k_ff      <= '0;
         ch_ff     <= '0;
         frame_ff  <= '0;
      end
      if (cmd.setup) begin
         prod_ff <= PROD_W'(rate_ff) * PROD_W'(ms_ff);
      end
      if (cmd.take_frames) begin
         frames_ff <= dnum_ff[CNT_W-1:0];
         fq_ff     <= fade_prod[FADE_W-1:RECIP_SHIFT];
      end
      if (cmd.take_n) begin
         n_ff <= n_in;
      end
      if (cmd.take_data) begin
         samp_ff <= ram_q;
      end else if (cmd.take_scale) begin
         samp_ff <= qres[SAMPLE_W-1:0];
      end
      if (cmd.mul) begin
         mul_ff <= scaled;
      end
      if (cmd.emit) begin
         k_ff <= k_ff + 1'b1;
         if (ch_ff == nch_eff - 1'b1) begin
            ch_ff    <= '0;
            frame_ff <= frame_ff + 1'b1;
         end else begin
            ch_ff <= ch_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff  <= padded ? '0 : samp_ff;
         rsp_pad_ff   <= padded;
         rsp_last_ff  <= k_ff + 1'b1 == req_ff;
         rsp_under_ff <= under_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_under_ff, rsp_pad_ff};

   assign st.in_push   = req_tuser == MODE_PUSH;
   assign st.in_zero   = in_count == '0;
   assign st.fade      = fade_ff;
   assign st.div_done  = ddone_ff;
   assign st.copy_now  = k_ff < copied_ff;
   assign st.fade_now  = fade_ff && (frame_ff < n_ff);
   assign st.last_item = k_ff + 1'b1 == req_ff;
   assign st.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

/* rtl/core/pcfi_ctrl.sv */
module pcfi_ctrl
   import pcfi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_DIV1  = 4'd2;
   localparam logic [3:0] S_DIV2  = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_DATA  = 4'd5;
   localparam logic [3:0] S_SMUL  = 4'd6;
   localparam logic [3:0] S_SDIVS = 4'd7;
   localparam logic [3:0] S_SDIV  = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      cmd      = '0;
      cmd.div_sel = DIV_FRAMES;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (!st.in_push && !st.in_zero) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            if (st.fade) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV1;
            end else begin
               state_in = S_READ;
            end
         end
         S_DIV1: begin
            if (st.div_done) begin
               cmd.take_frames = 1'b1;
               state_in        = S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.take_n = 1'b1;
            state_in   = S_READ;
         end
         S_READ: begin
            if (st.copy_now) begin
               cmd.rd   = 1'b1;
               state_in = S_DATA;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DATA: begin
            cmd.take_data = 1'b1;
            state_in      = st.fade_now ? S_SMUL : S_EMIT;
         end
         S_SMUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SDIVS;
         end
         S_SDIVS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SCALE;
            state_in      = S_SDIV;
         end
         S_SDIV: begin
            cmd.div_sel = DIV_SCALE;
            if (st.div_done) begin
               cmd.take_scale = 1'b1;
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the result register frees up
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = st.last_item ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/core/pcm_playout_fifo_fade_in.sv */
// channel  direction  tdata                                   tuser / tlast
// req      in         [15:0] sample, [22:16] request_count    tuser: mode
// rsp      out        [15:0] out_sample                       tuser: [0] padded, [1] underrun;
//                                                             tlast: last
// csr      in         csr_wdata to register csr_addr on csr_we
//
// A push is taken in the idle state. A request takes a load and a setup state, then read, data and emit
// states per queued sample and read and emit per padding sample; a faded sample adds a multiply, a
// divider start and a pass of the shared one-bit-per-cycle divider, and a fading block first
// works out its frame count and fade length with the divider.
// Reset is synchronous: it clears pointers, fill level and fade arming, and restores config.
// A held result stalls the sequencer only when the next result is ready.
module pcm_playout_fifo_fade_in
   import pcfi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // sample, request_count, zero fill
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,  // out_sample
   output logic                  rsp_tlast,
   output logic [RSP_USER_W-1:0] rsp_tuser,  // padded, underrun
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type st;

   pcfi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   pcfi_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_underrun_pads: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("underrun block carries queued data");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("padding sample is not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

/* test/tb_top.sv */
module tb_top
   import pcfi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SAMPLE_W-1:0] smp;
      logic                last;
      logic                padded;
      logic                underrun;
   } play_sample_type;

   typedef struct {
      logic        mode;
      logic [15:0] smp;
      logic [6:0]  cnt;
      logic        has_exp;
      logic [15:0] exp_smp;
      logic        exp_pad;
      logic        exp_und;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;
   logic                  rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pcm_playout_fifo_fade_in u_top (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [15:0] fifo_mem [FIFO_DEPTH];
   int unsigned rd_ptr, wr_ptr, level;
   bit          fade_armed;
   int unsigned chans_cfg, rate_cfg, ms_cfg, fade_en_cfg;

   play_sample_type expected_samples[$];
   int  mismatches = 0;
   bit  failed = 0;
   bit  stall_on = 0;
   int  stall_len = 0;

   function automatic int round_gain(int s, int k, int n);
      longint a, d, q;
      a = 2 * longint'(s) * k + n;
      d = 2 * longint'(n);
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return int'(q);
   endfunction

   task automatic predict_item(input logic mode, input logic [15:0] smp,
                               input logic [6:0] cnt);
      int blk[MAX_BLOCK];
      int unsigned req, got, nch, frames, fframes, n;
      bit und;
      play_sample_type r;
      if (mode == MODE_PUSH) begin
         if (level < FIFO_DEPTH) begin
            fifo_mem[wr_ptr] = smp;
            wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
            level++;
         end
         return;
      end
      req = (cnt > MAX_BLOCK) ? MAX_BLOCK : cnt;
      if (req == 0) return;
      got = (level < req) ? level : req;
      for (int k = 0; k < req; k++) begin
         if (k < got) begin
            blk[k] = $signed(fifo_mem[rd_ptr]);
            rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
         end else begin
            blk[k] = 0;
         end
      end
      level -= got;
      und = (got == 0);
      if (fade_en_cfg != 0 && fade_armed && got > 0) begin
         nch = (chans_cfg == 0) ? 1 : chans_cfg;
         frames = got / nch;
         fframes = (rate_cfg * ms_cfg) / MS_PER_S;
         if (fframes < 1) fframes = 1;
         n = (fframes < frames) ? fframes : frames;
         for (int i = 0; i < n; i++)
            for (int c = 0; c < nch; c++)
               if (i * nch + c < MAX_BLOCK)
                  blk[i*nch+c] = round_gain(blk[i*nch+c], i + 1, n);
         fade_armed = 0;
      end
      if (fade_en_cfg != 0 && und) fade_armed = 1;
      for (int k = 0; k < req; k++) begin
         r.smp = blk[k][15:0];
         r.last = (k + 1 == req);
         r.padded = (k >= got);
         r.underrun = und;
         expected_samples.push_back(r);
      end
   endtask

   task automatic send_item(input logic mode, input logic [15:0] smp,
                            input logic [6:0] cnt);
      // random gap ahead of the transfer, zero most of the time to form bursts
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, cnt, smp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(mode, smp, cnt);
   endtask

   task automatic drain_block;
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input int unsigned val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CFG_NUM_CHANNELS: chans_cfg   = val & 4'hF;
         CFG_SAMPLE_RATE:  rate_cfg    = val & 18'h3FFFF;
         CFG_FADE_MS:      ms_cfg      = val & 10'h3FF;
         default:          fade_en_cfg = val & 1;
      endcase
      @(posedge clock);
   endtask

   // receiver: random stall pattern with calm stretches
   always @(posedge clock) begin
      play_sample_type got, exp;
      if (rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[1]};
         if (expected_samples.size() == 0) begin
            failed <= 1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected sample %h", got);
         end else begin
            exp = expected_samples.pop_front();
            if (got !== exp) begin
               failed <= 1;
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected smp=%h last=%b pad=%b und=%b,",
                            " got smp=%h last=%b pad=%b und=%b"},
                           exp.smp, exp.last, exp.padded, exp.underrun,
                           got.smp, got.last, got.padded, got.underrun);
            end
         end
      end
      if (stall_len == 0) begin
         stall_on  = ($urandom_range(0, 2) == 0);
         stall_len = $urandom_range(1, 12);
      end else begin
         stall_len--;
      end
      rsp_tready <= reset ? 1'b0 : (stall_on ? ($urandom_range(0, 1) == 1) : 1'b1);
   end

   task automatic random_phase(input int items);
      int k;
      k = 0;
      while (k < items) begin
         if ($urandom_range(0, 9) < 8) begin
            // well-formed: a few pushes then a request, sometimes an underrun
            int pushes;
            pushes = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            for (int p = 0; p < pushes; p++) send_item(MODE_PUSH, $urandom, $urandom);
            send_item(~MODE_PUSH, $urandom, $urandom_range(1, 64));
            k += pushes + 1;
         end else begin
            send_item(~MODE_PUSH, $urandom, $urandom_range(0, 127));
            k++;
         end
      end
   endtask

   dir_row_type dir_rows[13] = '{
      '{1'b1, 16'h0000, 7'd4,  1'b1, 16'h0000, 1'b1, 1'b1},  // underrun after reset
      '{1'b0, 16'h7FFF, 7'd0,  1'b0, 16'h0, 1'b0, 1'b0},
      '{1'b0, 16'h8000, 7'd0,  1'b0, 16'h0, 1'b0, 1'b0},
      '{1'b0, 16'hFFFF, 7'd0,  1'b0, 16'h0, 1'b0, 1'b0},
      '{1'b0, 16'h0001, 7'd0,  1'b0, 16'h0, 1'b0, 1'b0},
      '{1'b1, 16'hFFFF, 7'd0,  1'b0, 16'h0, 1'b0, 1'b0},     // zero request
      '{1'b1, 16'hABCD, 7'd6,  1'b0, 16'h0, 1'b0, 1'b0},     // faded, with padding
      '{1'b1, 16'h0000, 7'd127,1'b1, 16'h0000, 1'b1, 1'b1},  // saturated underrun
      '{1'b0, 16'h1234, 7'h7F, 1'b0, 16'h0, 1'b0, 1'b0},
      '{1'b0, 16'hEDCB, 7'h7F, 1'b0, 16'h0, 1'b0, 1'b0},
      '{1'b0, 16'h5555, 7'h7F, 1'b0, 16'h0, 1'b0, 1'b0},
      '{1'b1, 16'h0000, 7'd3,  1'b0, 16'h0, 1'b0, 1'b0},     // incomplete frame
      '{1'b1, 16'h0000, 7'd64, 1'b0, 16'h0, 1'b0, 1'b0}
   };

   initial begin
      rd_ptr = 0; wr_ptr = 0; level = 0; fade_armed = 0;
      chans_cfg = 2; rate_cfg = 48000; ms_cfg = 10; fade_en_cfg = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) begin
         int n_new;
         n_new = (dir_rows[i].cnt > MAX_BLOCK) ? MAX_BLOCK : dir_rows[i].cnt;
         send_item(dir_rows[i].mode, dir_rows[i].smp, dir_rows[i].cnt);
         // the newest entries of the queue belong to this row
         if (dir_rows[i].has_exp)
            for (int j = expected_samples.size() - n_new; j < expected_samples.size(); j++)
               if (expected_samples[j].smp !== dir_rows[i].exp_smp ||
                   expected_samples[j].padded !== dir_rows[i].exp_pad ||
                   expected_samples[j].underrun !== dir_rows[i].exp_und) begin
                  failed = 1;
                  $display("row %0d: predictor disagrees with table", i);
               end
      end
      drain_block();
      // short fades, one channel, extremes of the registers
      write_reg(CFG_NUM_CHANNELS, 1);
      write_reg(CFG_SAMPLE_RATE, 8000);
      write_reg(CFG_FADE_MS, 1);
      random_phase(90);
      drain_block();
      write_reg(CFG_NUM_CHANNELS, 0);
      write_reg(CFG_FADE_MS, 0);
      random_phase(60);
      drain_block();
      write_reg(CFG_NUM_CHANNELS, 15);
      write_reg(CFG_SAMPLE_RATE, 192000);
      write_reg(CFG_FADE_MS, 1000);
      random_phase(60);
      drain_block();
      write_reg(CFG_FADE_ENABLE, 0);
      write_reg(CFG_NUM_CHANNELS, 3);
      write_reg(CFG_SAMPLE_RATE, 9000);
      write_reg(CFG_FADE_MS, 2);
      random_phase(60);
      drain_block();
      write_reg(CFG_FADE_ENABLE, 1);
      write_reg(CFG_NUM_CHANNELS, 8);
      write_reg(CFG_SAMPLE_RATE, 262143);
      write_reg(CFG_FADE_MS, 1023);
      random_phase(90);
      drain_block();
      if (expected_samples.size() != 0) failed = 1;
      if (!failed && mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/pcfi_pkg.sv
rtl/core/pcfi_ram.sv
rtl/core/pcfi_datapath.sv
rtl/core/pcfi_ctrl.sv
rtl/core/pcm_playout_fifo_fade_in.sv
test/tb_top.sv
